// File: rtl/pvmrc_pkg.sv
// Shared constants, tables and register indexes of the planar video crop marker.
// No dependencies; the channel interfaces and the top level import this package.
`timescale 1ns / 1ps

package pvmrc_pkg;

   localparam int REGION_SLOTS   = 4;
   localparam int COORD_BITS     = 16;
   localparam int FRAME_BITS     = 16;
   localparam int SUM_BITS       = FRAME_BITS + 1;
   localparam int RECT_BITS      = 4 * COORD_BITS;
   localparam int PIXEL_BITS     = 8;
   localparam int MASK_BITS      = 4;
   localparam int MODE_BITS      = 3;
   localparam int COUNT_BITS     = 3;
   localparam int PLANE_BITS     = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHROMA_MODE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_COUNT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION0_RECT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION1_RECT = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION2_RECT = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION3_RECT = 3'd7;

   // Plane numbers
   localparam logic [PLANE_BITS-1:0] PLANE_LUMA  = 2'd0;
   localparam logic [PLANE_BITS-1:0] PLANE_CB    = 2'd1;
   localparam logic [PLANE_BITS-1:0] PLANE_CR    = 2'd2;
   localparam logic [PLANE_BITS-1:0] PLANE_ALPHA = 2'd3;

   // Reset values of the configuration registers
   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(1920);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(1080);
   localparam logic [MODE_BITS-1:0]  CHROMA_MODE_RESET  = 3'd0;
   localparam logic [COUNT_BITS-1:0] REGION_COUNT_RESET = 3'd1;

   typedef logic [RECT_BITS-1:0] rect_type;

   // Chroma subsampling per mode: 420, 411, 422, 444, 444 alpha, mono, mono, mono
   localparam logic [1:0] CHROMA_HSHIFT [8] = '{2'd1, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
   localparam logic [1:0] CHROMA_VSHIFT [8] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
   localparam logic [2:0] MODE_PLANES   [8] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd1, 3'd1, 3'd1};

endpackage

// File: rtl/pvmrc_if.sv
// Valid/ready channel interfaces of the crop marker: sample input, tagged output, config writes.
// Depends on pvmrc_pkg for the field widths.
`timescale 1ns / 1ps

interface pvmrc_req_if;
   import pvmrc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_in;
   logic                  start_of_frame;

   modport source (output valid, output pixel_in, output start_of_frame, input ready);
   modport sink   (input valid, input pixel_in, input start_of_frame, output ready);
endinterface

interface pvmrc_rsp_if;
   import pvmrc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic [MASK_BITS-1:0]  region_hits;
   logic [PLANE_BITS-1:0] plane_number;
   logic                  plane_done;
   logic                  frame_done;
   logic [MASK_BITS-1:0]  bad_regions;

   modport source (output valid, output pixel_out, output region_hits, output plane_number,
                   output plane_done, output frame_done, output bad_regions, input ready);
   modport sink   (input valid, input pixel_out, input region_hits, input plane_number,
                   input plane_done, input frame_done, input bad_regions, output ready);
endinterface

interface pvmrc_csr_if;
   import pvmrc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/planar_video_multi_region_crop.sv
// Multi-region crop window marker for planar YUV frames (top level).
// Depends on pvmrc_pkg and the channel interfaces in pvmrc_if.sv.
`timescale 1ns / 1ps

// Takes one sample byte per clock in raster order, plane after plane, and returns each
// byte in the next cycle tagged with its plane, the crop rectangles that contain it, the
// rectangles that fail the bounds/size/divisibility checks, and end-of-plane and
// end-of-frame flags. Throughput is one item per clock while the output is not stalled: the
// column/row/plane counters and the four rectangle compares all update together, and the
// output register lets a new item in whenever the held result is being taken. Config writes
// are taken at any time (csr ready is always high) and act on the next item.
module planar_video_multi_region_crop
   import pvmrc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   pvmrc_req_if.sink   req,
   pvmrc_rsp_if.source rsp,
   pvmrc_csr_if.sink   csr
);

   // Configuration registers
   logic [FRAME_BITS-1:0] frame_width_ff, frame_height_ff;
   logic [MODE_BITS-1:0]  chroma_mode_ff;
   logic [COUNT_BITS-1:0] region_count_ff;
   rect_type              region_rect_ff [REGION_SLOTS];

   // Position state
   logic [FRAME_BITS-1:0] column_count_ff, column_count_in;
   logic [FRAME_BITS-1:0] row_count_ff, row_count_in;
   logic [PLANE_BITS-1:0] plane_index_ff, plane_index_in;

   // Output register
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic [MASK_BITS-1:0]  rsp_hits_ff, rsp_hits_in;
   logic [PLANE_BITS-1:0] rsp_plane_ff;
   logic                  rsp_plane_done_ff, rsp_plane_done_in;
   logic                  rsp_frame_done_ff, rsp_frame_done_in;
   logic [MASK_BITS-1:0]  rsp_bad_ff, rsp_bad_in;

   logic accept;
   logic [FRAME_BITS-1:0] fw1, fh1, chroma_w, chroma_h;
   logic [1:0]            mode_hs, mode_vs, cur_hs, cur_vs;
   logic [2:0]            plane_total;
   logic                  chroma_empty;
   logic [FRAME_BITS-1:0] base_col, base_row, base_pw, base_ph;
   logic [PLANE_BITS-1:0] base_plane;
   logic                  base_chroma, out_of_range;
   logic [FRAME_BITS-1:0] cur_col, cur_row, cur_pw, cur_ph;
   logic [PLANE_BITS-1:0] cur_plane, next_plane;
   logic                  cur_chroma, col_last, row_last, frame_end;
   logic [COORD_BITS-1:0] hmask, vmask;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // Plane geometry; a zero frame size tracks as one
   assign fw1          = (frame_width_ff == '0) ? FRAME_BITS'(1) : frame_width_ff;
   assign fh1          = (frame_height_ff == '0) ? FRAME_BITS'(1) : frame_height_ff;
   assign mode_hs      = CHROMA_HSHIFT[chroma_mode_ff];
   assign mode_vs      = CHROMA_VSHIFT[chroma_mode_ff];
   assign plane_total  = MODE_PLANES[chroma_mode_ff];
   assign chroma_w     = fw1 >> mode_hs;
   assign chroma_h     = fh1 >> mode_vs;
   assign chroma_empty = (chroma_w == '0) || (chroma_h == '0);
   assign hmask        = COORD_BITS'((1 << mode_hs) - 1);
   assign vmask        = COORD_BITS'((1 << mode_vs) - 1);

   // Resync on start of frame, or when the held position no longer fits the geometry
   assign base_col     = req.start_of_frame ? '0 : column_count_ff;
   assign base_row     = req.start_of_frame ? '0 : row_count_ff;
   assign base_plane   = req.start_of_frame ? PLANE_LUMA : plane_index_ff;
   assign base_chroma  = (base_plane == PLANE_CB) || (base_plane == PLANE_CR);
   assign base_pw      = base_chroma ? chroma_w : fw1;
   assign base_ph      = base_chroma ? chroma_h : fh1;
   assign out_of_range = ({1'b0, base_plane} >= plane_total) || (base_chroma && chroma_empty)
                         || (base_col >= base_pw) || (base_row >= base_ph);

   assign cur_col    = out_of_range ? '0 : base_col;
   assign cur_row    = out_of_range ? '0 : base_row;
   assign cur_plane  = out_of_range ? PLANE_LUMA : base_plane;
   assign cur_pw     = out_of_range ? fw1 : base_pw;
   assign cur_ph     = out_of_range ? fh1 : base_ph;
   assign cur_chroma = (cur_plane == PLANE_CB) || (cur_plane == PLANE_CR);
   assign cur_hs     = cur_chroma ? mode_hs : 2'd0;
   assign cur_vs     = cur_chroma ? mode_vs : 2'd0;

   // Rectangle checks and hit test, one lane per slot
   for (genvar k = 0; k < MASK_BITS; k++) begin : g_region
      if (k < REGION_SLOTS) begin : g_used
         logic [COORD_BITS-1:0] rx, ry, rw, rh, nx, ny, nw, nh;
         logic                  in_use, bad;
         assign rx     = region_rect_ff[k][0*COORD_BITS +: COORD_BITS];
         assign ry     = region_rect_ff[k][1*COORD_BITS +: COORD_BITS];
         assign rw     = region_rect_ff[k][2*COORD_BITS +: COORD_BITS];
         assign rh     = region_rect_ff[k][3*COORD_BITS +: COORD_BITS];
         assign in_use = region_count_ff > COUNT_BITS'(k);
         assign bad    = (rw == '0) || (rh == '0)
                         || (SUM_BITS'(rx) + SUM_BITS'(rw) > SUM_BITS'(frame_width_ff))
                         || (SUM_BITS'(ry) + SUM_BITS'(rh) > SUM_BITS'(frame_height_ff))
                         || ((plane_total > 3'd1) && (((rw & hmask) != '0)
                                                      || ((rh & vmask) != '0)));
         assign nx = rx >> cur_hs;
         assign ny = ry >> cur_vs;
         assign nw = rw >> cur_hs;
         assign nh = rh >> cur_vs;
         assign rsp_bad_in[k]  = in_use && bad;
         assign rsp_hits_in[k] = in_use && !bad
                                 && (SUM_BITS'(cur_col) >= SUM_BITS'(nx))
                                 && (SUM_BITS'(cur_col) < SUM_BITS'(nx) + SUM_BITS'(nw))
                                 && (SUM_BITS'(cur_row) >= SUM_BITS'(ny))
                                 && (SUM_BITS'(cur_row) < SUM_BITS'(ny) + SUM_BITS'(nh));
      end else begin : g_unused
         assign rsp_bad_in[k]  = 1'b0;
         assign rsp_hits_in[k] = 1'b0;
      end
   end

   // Next plane after the last byte of this one, skipping empty chroma planes
   always_comb begin
      next_plane = PLANE_LUMA;
      frame_end  = 1'b0;
      unique case (cur_plane)
         PLANE_LUMA: begin
            if (plane_total >= 3'd3 && !chroma_empty) begin
               next_plane = PLANE_CB;
            end else if (plane_total == 3'd4) begin
               next_plane = PLANE_ALPHA;
            end else begin
               frame_end = 1'b1;
            end
         end
         PLANE_CB: begin
            next_plane = PLANE_CR;
         end
         PLANE_CR: begin
            if (plane_total == 3'd4) begin
               next_plane = PLANE_ALPHA;
            end else begin
               frame_end = 1'b1;
            end
         end
         PLANE_ALPHA: begin
            frame_end = 1'b1;
         end
      endcase
   end

   assign col_last          = cur_col == cur_pw - FRAME_BITS'(1);
   assign row_last          = cur_row == cur_ph - FRAME_BITS'(1);
   assign rsp_plane_done_in = col_last && row_last;
   assign rsp_frame_done_in = col_last && row_last && frame_end;

   always_comb begin
      column_count_in = cur_col + FRAME_BITS'(1);
      row_count_in    = cur_row;
      plane_index_in  = cur_plane;
      if (col_last) begin
         column_count_in = '0;
         if (row_last) begin
            row_count_in   = '0;
            plane_index_in = next_plane;
         end else begin
            row_count_in = cur_row + FRAME_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         plane_index_ff  <= PLANE_LUMA;
      end else if (accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         plane_index_ff  <= plane_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pixel_ff      <= req.pixel_in;
         rsp_hits_ff       <= rsp_hits_in;
         rsp_plane_ff      <= cur_plane;
         rsp_plane_done_ff <= rsp_plane_done_in;
         rsp_frame_done_ff <= rsp_frame_done_in;
         rsp_bad_ff        <= rsp_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         chroma_mode_ff  <= CHROMA_MODE_RESET;
         region_count_ff <= REGION_COUNT_RESET;
         for (int i = 0; i < REGION_SLOTS; i++) begin
            region_rect_ff[i] <= '0;
         end
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr.data[FRAME_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr.data[FRAME_BITS-1:0];
            CSR_CHROMA_MODE:  chroma_mode_ff  <= csr.data[MODE_BITS-1:0];
            CSR_REGION_COUNT: region_count_ff <= csr.data[COUNT_BITS-1:0];
            CSR_REGION0_RECT, CSR_REGION1_RECT, CSR_REGION2_RECT, CSR_REGION3_RECT: begin
               // slots beyond the build's count drop the write
               if (int'(csr.index[1:0]) < REGION_SLOTS) begin
                  region_rect_ff[csr.index[1:0]] <= csr.data[RECT_BITS-1:0];
               end
            end
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pixel_out    = rsp_pixel_ff;
   assign rsp.region_hits  = rsp_hits_ff;
   assign rsp.plane_number = rsp_plane_ff;
   assign rsp.plane_done   = rsp_plane_done_ff;
   assign rsp.frame_done   = rsp_frame_done_ff;
   assign rsp.bad_regions  = rsp_bad_ff;

   // A held result is never overwritten by a new item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("item accepted while result stalled");

   // Every accepted item shows up in the output register next cycle
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item lost");

   // End of frame only on the last byte of a plane
   a_frame_in_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_done_ff |-> rsp_plane_done_ff)
      else $error("frame_done without plane_done");

   // A failing rectangle never reports a hit
   a_bad_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hits_ff & rsp_bad_ff) == '0)
      else $error("hit on bad rectangle");

   // Position after an item always starts a row when a plane ends
   a_plane_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_plane_done_in |=> column_count_ff == '0 && row_count_ff == '0)
      else $error("counters not cleared at plane end");

endmodule
